@@ rtl/mkpd_pkg.sv @@
// ----------------------------------------------------------------------------
// Keypad scan decoder package
// Shared widths, register indexes and small decode helpers.
// ----------------------------------------------------------------------------
package mkpd_pkg;

  localparam int NIBBLE_W = 4;
  localparam int CODE_W   = 5;
  localparam int DELAY_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DELAY_W;

  typedef logic [NIBBLE_W-1:0]   nibble_t;
  typedef logic [CODE_W-1:0]     key_code_t;
  typedef logic [DELAY_W-1:0]    delay_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REPEAT_ENABLE     = 2'd0,
    REG_ACCELERATE_ENABLE = 2'd1,
    REG_FIRST_DELAY       = 2'd2,
    REG_REPEAT_DELAY      = 2'd3
  } cfg_reg_t;

  localparam delay_t    FIRST_DELAY_RESET  = 16'd100;
  localparam delay_t    REPEAT_DELAY_RESET = 16'd20;
  localparam delay_t    HOLD_COUNT_MAX     = 16'hFFFF;
  localparam key_code_t NO_KEY             = 5'd0;

  // True when exactly one of the four bits is set.
  function automatic logic is_single_bit(input nibble_t v);
    logic [2:0] n;
    n = {2'b00, v[0]} + {2'b00, v[1]} + {2'b00, v[2]} + {2'b00, v[3]};
    return n == 3'd1;
  endfunction

  // Position of the lowest set bit, zero when none is set.
  function automatic logic [1:0] low_bit_index(input nibble_t v);
    logic [1:0] idx;
    idx = 2'd0;
    if (v[0]) begin
      idx = 2'd0;
    end else if (v[1]) begin
      idx = 2'd1;
    end else if (v[2]) begin
      idx = 2'd2;
    end else if (v[3]) begin
      idx = 2'd3;
    end
    return idx;
  endfunction

endpackage

@@ rtl/mkpd_scan_if.sv @@
// ----------------------------------------------------------------------------
// Keypad scan channel
// Carries one keypad scan word: two line samples and one row sample.
// ----------------------------------------------------------------------------
interface mkpd_scan_if
  import mkpd_pkg::*;
;
  logic    valid;
  logic    ready;
  nibble_t line_first;
  nibble_t line_second;
  nibble_t row_sample;

  modport source (output valid, output line_first, output line_second,
                  output row_sample, input ready);
  modport sink   (input valid, input line_first, input line_second,
                  input row_sample, output ready);
endinterface

@@ rtl/mkpd_key_if.sv @@
// ----------------------------------------------------------------------------
// Key code channel
// Carries one decoded key code word per scan.
// ----------------------------------------------------------------------------
interface mkpd_key_if
  import mkpd_pkg::*;
;
  logic      valid;
  logic      ready;
  key_code_t key_code;

  modport source (output valid, output key_code, input ready);
  modport sink   (input valid, input key_code, output ready);
endinterface

@@ rtl/matrix_keypad_scan_decoder_top.sv @@
// ----------------------------------------------------------------------------
// Matrix keypad scan decoder
// Debounces 4x4 keypad scans and reports key presses with auto-repeat.
// ----------------------------------------------------------------------------
// Each scan word carries two line samples and a row sample. When the line
// samples agree and exactly one line and one row are active, the key number
// line*4 + row + 1 is formed; otherwise the word yields code 0. A newly
// pressed key (a different key, or any key after a release) is reported at
// once. With repeat enabled, a held key is reported again once its hold count
// exceeds the hold limit; the limit starts at first_delay and, with
// acceleration, drops to repeat_delay after the first repeat. The limit is
// reloaded from first_delay whenever no line is active, so a new first_delay
// takes effect at the next release. Every scan word produces exactly one
// result word, 0 meaning nothing to report. The block takes one scan word per
// clock unless a stalled output holds it: a word sits in the input register
// while the decode and the state update run, and its result then moves into
// the output register. The output register frees the input side, and a
// stalled output holds the pipeline only once both registers are full.
// Configuration registers are written through cfg_we, cfg_index and cfg_data
// and should only be changed while no scan word is in flight.
module matrix_keypad_scan_decoder_top
  import mkpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  mkpd_scan_if.sink   scan,
  mkpd_key_if.source  key,
  input  logic        cfg_we,
  input  cfg_idx_t    cfg_index,
  input  cfg_data_t   cfg_data
);

  // Configuration registers.
  logic   repeat_enable;
  logic   accelerate_enable;
  delay_t first_delay;
  delay_t repeat_delay;

  // Input register.
  logic    s1_valid;
  nibble_t s1_line_first;
  nibble_t s1_line_second;
  nibble_t s1_row_sample;

  // Key tracking state.
  key_code_t last_key;
  key_code_t last_key_next;
  logic      key_released;
  logic      key_released_next;
  delay_t    hold_count;
  delay_t    hold_count_next;
  delay_t    hold_limit;
  delay_t    hold_limit_next;

  // Output register.
  logic      out_valid;
  key_code_t out_code;
  key_code_t result_next;

  logic      out_free;
  logic      advance;
  logic      take;
  key_code_t code;
  delay_t    count_inc;

  assign out_free   = !out_valid || key.ready;
  assign advance    = s1_valid && out_free;
  assign scan.ready = !s1_valid || out_free;
  assign take       = scan.valid && scan.ready;

  assign key.valid    = out_valid;
  assign key.key_code = out_code;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_enable     <= 1'b1;
      accelerate_enable <= 1'b1;
      first_delay       <= FIRST_DELAY_RESET;
      repeat_delay      <= REPEAT_DELAY_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_REPEAT_ENABLE:     repeat_enable     <= cfg_data[0];
        REG_ACCELERATE_ENABLE: accelerate_enable <= cfg_data[0];
        REG_FIRST_DELAY:       first_delay       <= cfg_data;
        REG_REPEAT_DELAY:      repeat_delay      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_line_first  <= scan.line_first;
      s1_line_second <= scan.line_second;
      s1_row_sample  <= scan.row_sample;
    end
  end

  // Decode and key state update for the word in the input register.
  assign code = {1'b0, low_bit_index(s1_line_first), low_bit_index(s1_row_sample)}
                + 5'd1;
  assign count_inc = (hold_count != HOLD_COUNT_MAX) ? hold_count + 16'd1 : hold_count;

  always_comb begin
    last_key_next     = last_key;
    key_released_next = key_released;
    hold_count_next   = hold_count;
    hold_limit_next   = hold_limit;
    result_next       = NO_KEY;

    if (s1_line_first != s1_line_second) begin
      // Bouncing lines: nothing trustworthy in this scan.
      hold_count_next = '0;
    end else if (s1_line_first == '0) begin
      // All keys released.
      hold_count_next   = '0;
      key_released_next = 1'b1;
      hold_limit_next   = first_delay;
    end else if (!is_single_bit(s1_line_first) || !is_single_bit(s1_row_sample)) begin
      // Several keys at once, or no clean row: ignored.
      hold_count_next = '0;
    end else if (code != last_key || key_released) begin
      last_key_next     = code;
      key_released_next = 1'b0;
      hold_count_next   = '0;
      result_next       = code;
    end else if (repeat_enable) begin
      hold_count_next = count_inc;
      if (count_inc > hold_limit) begin
        hold_count_next = '0;
        if (accelerate_enable && hold_limit == first_delay) begin
          hold_limit_next = repeat_delay;
        end
        result_next = code;
      end
    end else begin
      hold_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_key     <= NO_KEY;
      key_released <= 1'b1;
      hold_count   <= '0;
      hold_limit   <= FIRST_DELAY_RESET;
    end else if (advance) begin
      last_key     <= last_key_next;
      key_released <= key_released_next;
      hold_count   <= hold_count_next;
      hold_limit   <= hold_limit_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (key.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_code <= result_next;
    end
  end

  // The hold count is cleared whenever it passes the limit.
  a_hold_within_limit : assert property (@(posedge clk) disable iff (rst)
    hold_count <= hold_limit)
    else $error("hold count exceeds hold limit");

  // A reported key becomes the tracked key and marks the key as held.
  a_report_tracks_key : assert property (@(posedge clk) disable iff (rst)
    (advance && result_next != NO_KEY) |=> (last_key == out_code) && !key_released)
    else $error("reported key not tracked");

  // A scan with no active line always marks the key as released.
  a_release_seen : assert property (@(posedge clk) disable iff (rst)
    (advance && s1_line_first == '0 && s1_line_second == '0) |=>
      key_released && out_code == NO_KEY)
    else $error("release not recorded");

  // With both registers full and the output stalled, no new scan is taken.
  a_stall_blocks_input : assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !key.ready) |-> !scan.ready)
    else $error("scan accepted while pipeline full");

endmodule
